>>> rtl/tfsf_pkg.sv
// Shared types and constants for the TCP flow sequence filter.
`timescale 1ns / 1ps
`default_nettype none
package tfsf_pkg;

  localparam int FLOW_ENTRIES_DEF = 1024;
  localparam int RING_DEPTH_DEF   = 10;
  localparam int QUEUE_DEPTH      = 2;
  localparam int ACT_W            = 11;
  localparam int CFG_IDX_W        = 8;

  localparam logic [63:0] IDLE_TIMEOUT_RESET = 64'd72000000;
  localparam logic [7:0]  RETX_LIMIT_RESET   = 8'd5;
  localparam logic [31:0] IP_HDR_BYTES       = 32'd20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETX_LIMIT   = 8'd1;

  typedef enum logic [2:0] {
    CAUSE_NON_TCP     = 3'd0,
    CAUSE_NEW_FLOW    = 3'd1,
    CAUSE_FULL_PASS   = 3'd2,
    CAUSE_IN_ORDER    = 3'd3,
    CAUSE_RETRANSMIT  = 3'd4,
    CAUSE_NO_FLOW     = 3'd5,
    CAUSE_LIMIT       = 3'd6,
    CAUSE_UNKNOWN_SEQ = 3'd7
  } cause_t;

  // Classified packet as queued between front and back
  typedef struct packed {
    logic        tcp;
    logic [95:0] key;
    logic [31:0] seq;
    logic        syn;
    logic [31:0] delta;
    logic [63:0] now;
  } item_t;

  // One slot of a flow's recent sequence ring
  typedef struct packed {
    logic [31:0] seq;
    logic [7:0]  cnt;
  } ring_t;

endpackage
`default_nettype wire

>>> rtl/tcp_flow_sequence_filter.sv
// Top level: configuration registers, front end, queue and back end.
// Non-TCP packets skip the flow table; TCP walks the flow table one entry a cycle, then
// searches up to RING_DEPTH-2 ring slots, each with a read request and a compare.
// The table walk sets the rate: one packet at a time.
// Reset: a clearing pass over all FLOW_ENTRIES entries runs with busy high.
// Results are shown for one cycle on out_valid; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module tcp_flow_sequence_filter import tfsf_pkg::*; #(
  parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF,
  parameter int RING_DEPTH   = RING_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_is_ipv4_tcp,
  input  wire logic [31:0]          in_source_address,
  input  wire logic [31:0]          in_dest_address,
  input  wire logic [15:0]          in_source_port,
  input  wire logic [15:0]          in_dest_port,
  input  wire logic [31:0]          in_sequence_number,
  input  wire logic                 in_syn_flag,
  input  wire logic                 in_fin_flag,
  input  wire logic [15:0]          in_ip_total_length,
  input  wire logic [3:0]           in_tcp_header_words,
  input  wire logic [63:0]          in_arrival_time,
  output logic                      out_valid,
  output logic                      out_drop,
  output logic [2:0]                out_cause,
  output logic [ACT_W-1:0]          out_active_flows,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  logic [63:0] idle_timeout_r;
  logic [7:0]  retx_limit_r;
  logic        full, clearing, q_valid, q_pop;
  item_t       q_item;

  assign cfg_ready = 1'b1;
  assign busy      = full | clearing;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= IDLE_TIMEOUT_RESET;
      retx_limit_r   <= RETX_LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDLE_TIMEOUT) begin
        idle_timeout_r <= cfg_data;
      end else if (cfg_index == CFG_RETX_LIMIT) begin
        retx_limit_r <= cfg_data[7:0];
      end
    end
  end

  tfsf_front u_front (
    .clk(clk), .rst_n(rst_n), .accept(start & ~busy),
    .is_ipv4_tcp(in_is_ipv4_tcp), .source_address(in_source_address),
    .dest_address(in_dest_address), .source_port(in_source_port),
    .dest_port(in_dest_port), .sequence_number(in_sequence_number),
    .syn_flag(in_syn_flag), .fin_flag(in_fin_flag),
    .ip_total_length(in_ip_total_length), .tcp_header_words(in_tcp_header_words),
    .arrival_time(in_arrival_time), .full(full),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  tfsf_back #(.FLOW_ENTRIES(FLOW_ENTRIES), .RING_DEPTH(RING_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .idle_timeout(idle_timeout_r), .retx_limit(retx_limit_r), .clearing(clearing),
    .out_strobe(out_valid), .out_drop(out_drop), .out_cause(out_cause),
    .out_active_flows(out_active_flows)
  );

endmodule
`default_nettype wire

>>> rtl/tfsf_ram.sv
// Simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tfsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/tfsf_front.sv
// Front end: accept packets, build flow key and payload step, queue them.
`timescale 1ns / 1ps
`default_nettype none
module tfsf_front import tfsf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic        is_ipv4_tcp,
  input  wire logic [31:0] source_address,
  input  wire logic [31:0] dest_address,
  input  wire logic [15:0] source_port,
  input  wire logic [15:0] dest_port,
  input  wire logic [31:0] sequence_number,
  input  wire logic        syn_flag,
  input  wire logic        fin_flag,
  input  wire logic [15:0] ip_total_length,
  input  wire logic [3:0]  tcp_header_words,
  input  wire logic [63:0] arrival_time,
  output logic             full,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_pop
);

  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  item_t            q_r [QUEUE_DEPTH];
  logic [QA_W-1:0]  wptr_r, rptr_r;
  logic [QC_W-1:0]  cnt_r;
  item_t            item;

  // Classify: flow key and sequence advance for an in-order packet
  always_comb begin
    item.tcp   = is_ipv4_tcp;
    item.key   = {source_address, dest_address, source_port, dest_port};
    item.seq   = sequence_number;
    item.syn   = syn_flag;
    item.delta = {16'b0, ip_total_length} - IP_HDR_BYTES - {26'b0, tcp_header_words, 2'b0}
                 + {31'b0, syn_flag | fin_flag};
    item.now   = arrival_time;
  end

  assign full    = (cnt_r == QC_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_r[rptr_r];

  // Hold classified packets until the back end takes them
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wptr_r] <= item;
    end
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (accept) begin
        wptr_r <= (wptr_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (q_pop) begin
        rptr_r <= (rptr_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QC_W'(accept) - QC_W'(q_pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/tfsf_back.sv
// Back end: flow table walk, ring search, table update and result.
`timescale 1ns / 1ps
`default_nettype none
module tfsf_back import tfsf_pkg::*; #(
  parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF,
  parameter int RING_DEPTH   = RING_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire item_t            q_item,
  output logic                  q_pop,
  input  wire logic [63:0]      idle_timeout,
  input  wire logic [7:0]       retx_limit,
  output logic                  clearing,
  output logic                  out_strobe,
  output logic                  out_drop,
  output logic [2:0]            out_cause,
  output logic [ACT_W-1:0]      out_active_flows
);

  localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int HT_W  = $clog2(RING_DEPTH);
  localparam int RA_W  = $clog2(FLOW_ENTRIES * RING_DEPTH);
  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

  typedef struct packed {
    logic            valid;
    logic [95:0]     key;
    logic [31:0]     exp;
    logic [63:0]     last;
    logic [HT_W-1:0] head;
    logic [HT_W-1:0] tail;
  } entry_t;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_HIT   = 7'b0001000,
    ST_RREQ  = 7'b0010000,
    ST_RCMP  = 7'b0100000,
    ST_MISS  = 7'b1000000
  } state_t;

  function automatic logic [HT_W-1:0] ht_inc(input logic [HT_W-1:0] v);
    return (v == HT_W'(RING_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  state_t           state_r;
  logic [IDX_W-1:0] idx_r, found_r, free_idx_r, idle_idx_r;
  logic             free_found_r, idle_found_r;
  item_t            item_r;
  entry_t           ent_r;
  logic [RA_W-1:0]  base_r;
  logic [HT_W-1:0]  ri_r;
  logic [CNT_W-1:0] count_r;
  logic             strobe_r, drop_r;
  cause_t           cause_r;

  logic             e_we;
  logic [IDX_W-1:0] e_waddr, e_raddr;
  entry_t           e_wdata, e_rdata;
  logic             r_we;
  logic [RA_W-1:0]  r_waddr, r_raddr;
  ring_t            r_wdata, r_rdata;

  logic             scan_match, scan_idle, in_order, ring_hit, over, not_full;
  logic             use_free, use_idle, do_open;
  logic [IDX_W-1:0] open_idx;
  logic [RA_W-1:0]  open_base, hit_base;
  logic [HT_W-1:0]  head_nx, tail_nx, ri_nx;
  logic [7:0]       cnt_nx;
  logic [CNT_W+ACT_W-1:0] count_ext;

  tfsf_ram #(.WIDTH($bits(entry_t)), .DEPTH(FLOW_ENTRIES)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  tfsf_ram #(.WIDTH($bits(ring_t)), .DEPTH(FLOW_ENTRIES * RING_DEPTH)) u_ring_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  // Decisions on the current entry and ring slot
  always_comb begin
    scan_match = e_rdata.valid && (e_rdata.key == item_r.key);
    scan_idle  = e_rdata.valid && ((item_r.now - e_rdata.last) > idle_timeout);
    in_order   = (item_r.seq == ent_r.exp);
    head_nx    = ht_inc(ent_r.head);
    tail_nx    = (ht_inc(head_nx) == ent_r.tail) ? ht_inc(ent_r.tail) : ent_r.tail;
    ri_nx      = ht_inc(ri_r);
    ring_hit   = (r_rdata.seq == item_r.seq);
    cnt_nx     = r_rdata.cnt + 8'd1;
    over       = (cnt_nx > retx_limit);
    not_full   = (count_r < CNT_W'(FLOW_ENTRIES));
    use_free   = item_r.syn && not_full && free_found_r;
    use_idle   = item_r.syn && !not_full && idle_found_r;
    do_open    = use_free || use_idle;
    open_idx   = use_free ? free_idx_r : idle_idx_r;
    open_base  = RA_W'(open_idx) * RA_W'(RING_DEPTH);
    hit_base   = RA_W'(found_r) * RA_W'(RING_DEPTH);
  end

  // Memory port control
  always_comb begin
    e_we    = 1'b0;
    e_waddr = found_r;
    e_wdata = ent_r;
    e_raddr = idx_r + 1'b1;
    r_we    = 1'b0;
    r_waddr = base_r + RA_W'(ri_r);
    r_wdata = {item_r.seq, 8'd0};
    r_raddr = base_r + RA_W'(ri_r);
    q_pop   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = idx_r;
        e_wdata = '0;
      end
      ST_IDLE: begin
        e_raddr = '0;
        q_pop   = q_valid;
      end
      ST_SCAN: begin
      end
      ST_HIT: begin
        if (in_order) begin
          e_we         = 1'b1;
          e_wdata.exp  = item_r.seq + item_r.delta;
          e_wdata.last = item_r.now;
          e_wdata.head = head_nx;
          e_wdata.tail = tail_nx;
          r_we         = 1'b1;
          r_waddr      = hit_base + RA_W'(ent_r.head);
        end
      end
      ST_RREQ: begin
      end
      ST_RCMP: begin
        if (ring_hit) begin
          r_we    = 1'b1;
          r_wdata = {item_r.seq, cnt_nx};
          e_we    = 1'b1;
          if (over) begin
            e_wdata.valid = 1'b0;
          end else begin
            e_wdata.last = item_r.now;
          end
        end
      end
      ST_MISS: begin
        if (do_open) begin
          e_we    = 1'b1;
          e_waddr = open_idx;
          e_wdata = {1'b1, item_r.key, item_r.seq + 32'd1, item_r.now,
                     HT_W'(1), HT_W'(0)};
          r_we    = 1'b1;
          r_waddr = open_base;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      count_r      <= '0;
      strobe_r     <= 1'b0;
      free_found_r <= 1'b0;
      idle_found_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            idx_r   <= '0;
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            item_r <= q_item;
            if (!q_item.tcp) begin
              strobe_r <= 1'b1;
              drop_r   <= 1'b0;
              cause_r  <= CAUSE_NON_TCP;
            end else begin
              idx_r        <= '0;
              free_found_r <= 1'b0;
              idle_found_r <= 1'b0;
              state_r      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_match) begin
            found_r <= idx_r;
            ent_r   <= e_rdata;
            state_r <= ST_HIT;
          end else begin
            if (!e_rdata.valid && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= idx_r;
            end
            if (scan_idle && !idle_found_r) begin
              idle_found_r <= 1'b1;
              idle_idx_r   <= idx_r;
            end
            if (idx_r == LAST_IDX) begin
              state_r <= ST_MISS;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_HIT: begin
          if (in_order) begin
            strobe_r <= 1'b1;
            drop_r   <= 1'b0;
            cause_r  <= CAUSE_IN_ORDER;
            state_r  <= ST_IDLE;
          end else begin
            base_r <= hit_base;
            ri_r   <= ent_r.tail;
            if (ent_r.tail == ent_r.head) begin
              strobe_r <= 1'b1;
              drop_r   <= 1'b1;
              cause_r  <= CAUSE_UNKNOWN_SEQ;
              state_r  <= ST_IDLE;
            end else begin
              state_r <= ST_RREQ;
            end
          end
        end
        ST_RREQ: begin
          state_r <= ST_RCMP;
        end
        ST_RCMP: begin
          if (ring_hit) begin
            strobe_r <= 1'b1;
            state_r  <= ST_IDLE;
            if (over) begin
              drop_r  <= 1'b1;
              cause_r <= CAUSE_LIMIT;
              if (count_r != '0) begin
                count_r <= count_r - 1'b1;
              end
            end else begin
              drop_r  <= 1'b0;
              cause_r <= CAUSE_RETRANSMIT;
            end
          end else if (ri_nx == ent_r.head) begin
            strobe_r <= 1'b1;
            drop_r   <= 1'b1;
            cause_r  <= CAUSE_UNKNOWN_SEQ;
            state_r  <= ST_IDLE;
          end else begin
            ri_r    <= ri_nx;
            state_r <= ST_RREQ;
          end
        end
        ST_MISS: begin
          strobe_r <= 1'b1;
          state_r  <= ST_IDLE;
          if (!item_r.syn) begin
            drop_r  <= 1'b1;
            cause_r <= CAUSE_NO_FLOW;
          end else if (do_open) begin
            drop_r  <= 1'b0;
            cause_r <= CAUSE_NEW_FLOW;
            if (use_free) begin
              count_r <= count_r + 1'b1;
            end
          end else begin
            drop_r  <= 1'b0;
            cause_r <= CAUSE_FULL_PASS;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign count_ext        = {{ACT_W{1'b0}}, count_r};
  assign clearing         = (state_r == ST_CLEAR);
  assign out_strobe       = strobe_r;
  assign out_drop         = drop_r;
  assign out_cause        = cause_r;
  assign out_active_flows = count_ext[ACT_W-1:0];

endmodule
`default_nettype wire
